// ----- sv/tgbc_pkg.sv -----
// shared constants, command/status types and helpers for the tile grid box collision block
// no dependencies
package tgbc_pkg;

   localparam int TILE_PIXELS   = 8;
   localparam int LEVEL_COLUMNS = 32;
   localparam int MAP_CELLS     = 1024;

   localparam int TILE_SHIFT = $clog2(TILE_PIXELS);
   localparam int ADDR_W     = $clog2(MAP_CELLS);
   localparam int IN_PIX_W   = 12;
   localparam int PIX_W      = IN_PIX_W + 1;
   localparam int TILE_W     = PIX_W - TILE_SHIFT;
   localparam int DIM_W      = 7;
   localparam int CODE_W     = 8;
   localparam int SIZE_W     = 9;
   localparam int INDEX_W    = 10;
   localparam int CELLS_W    = 2 * DIM_W;
   localparam int PROD_W     = TILE_W + DIM_W + 1;
   localparam int IDX_W      = PROD_W + 1;
   localparam int SPAN_W     = PIX_W + 3;
   localparam int SWEEP_W    = 11;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID_FIRST = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOLID_LAST  = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // scan phases of a query
   localparam logic [2:0] PH_LEFT   = 3'd0;
   localparam logic [2:0] PH_RIGHT  = 3'd1;
   localparam logic [2:0] PH_GROUND = 3'd2;
   localparam logic [2:0] PH_FALL   = 3'd3;
   localparam logic [2:0] PH_LSPAN  = 3'd4;
   localparam logic [2:0] PH_RSPAN  = 3'd5;

   localparam logic [3:0] CMD_NONE    = 4'd0;
   localparam logic [3:0] CMD_WRITE   = 4'd1;
   localparam logic [3:0] CMD_CAPTURE = 4'd2;
   localparam logic [3:0] CMD_PREP    = 4'd3;
   localparam logic [3:0] CMD_SETUP   = 4'd4;
   localparam logic [3:0] CMD_READ    = 4'd5;
   localparam logic [3:0] CMD_INNER   = 4'd6;
   localparam logic [3:0] CMD_OUTER   = 4'd7;
   localparam logic [3:0] CMD_RECORD  = 4'd8;
   localparam logic [3:0] CMD_EMIT    = 4'd9;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] ph;
      logic       hit;
   } cmd_type;

   typedef struct packed {
      logic empty;   // inner range holds no tile
      logic oor;     // sweep column left the level
      logic last;    // inner scan at its last tile
      logic hit;     // tile just read is solid
   } status_type;

   // pixel to tile, truncating toward zero
   function automatic logic signed [TILE_W-1:0] tile_of(input logic signed [PIX_W-1:0] pix);
      logic signed [PIX_W-1:0] adj;
      adj = pix[PIX_W-1] ? pix + PIX_W'(TILE_PIXELS - 1) : pix;
      return TILE_W'(adj >>> TILE_SHIFT);
   endfunction

   function automatic logic [SWEEP_W-1:0] clamp_span(input logic signed [SPAN_W-1:0] v);
      logic signed [SPAN_W-1:0] top;
      top = SPAN_W'((1 << SWEEP_W) - 1);
      if (v < 0) return '0;
      else if (v > top) return '1;
      else return v[SWEEP_W-1:0];
   endfunction

endpackage

// ----- sv/tile_grid_box_collision.sv -----
// tile grid box collision, top level: a cell write is taken while busy stays low.
// a query holds busy while its six scan phases run; each tile lookup goes through the
// single registered read port of the tile store.
// rsp_valid strobes in the cycle in which busy falls; the receiver cannot stall.
// synchronous reset restores config defaults and idles the controller; the tile store
// is not cleared and holds garbage until written.
module tile_grid_box_collision (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tgbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgbc_pkg::CODE_W-1:0]      csr_wdata,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [tgbc_pkg::INDEX_W-1:0]     req_cell_index,
   input  logic [tgbc_pkg::CODE_W-1:0]      req_tile_code,
   input  logic signed [tgbc_pkg::IN_PIX_W-1:0] req_box_x,
   input  logic signed [tgbc_pkg::IN_PIX_W-1:0] req_box_y,
   input  logic [tgbc_pkg::SIZE_W-1:0]      req_box_width,
   input  logic [tgbc_pkg::SIZE_W-1:0]      req_box_height,
   input  logic signed [tgbc_pkg::IN_PIX_W-1:0] req_probe_y,
   output logic                             rsp_valid,
   output logic                             rsp_wall_left,
   output logic                             rsp_wall_right,
   output logic                             rsp_on_ground,
   output logic signed [tgbc_pkg::IN_PIX_W-1:0] rsp_ground_y,
   output logic                             rsp_falling,
   output logic [tgbc_pkg::SWEEP_W-1:0]     rsp_sweep_x,
   output logic [tgbc_pkg::SWEEP_W-1:0]     rsp_sweep_width
);
   import tgbc_pkg::*;

   cmd_type    cmd;
   status_type st;

   tgbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .st        (st)
   );

   tgbc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cell_index  (req_cell_index),
      .req_tile_code   (req_tile_code),
      .req_box_x       (req_box_x),
      .req_box_y       (req_box_y),
      .req_box_width   (req_box_width),
      .req_box_height  (req_box_height),
      .req_probe_y     (req_probe_y),
      .cmd             (cmd),
      .st              (st),
      .rsp_wall_left   (rsp_wall_left),
      .rsp_wall_right  (rsp_wall_right),
      .rsp_on_ground   (rsp_on_ground),
      .rsp_ground_y    (rsp_ground_y),
      .rsp_falling     (rsp_falling),
      .rsp_sweep_x     (rsp_sweep_x),
      .rsp_sweep_width (rsp_sweep_width)
   );

endmodule

// ----- sv/tgbc_ctrl.sv -----
// controller state machine: sequences writes and the six scan phases of a query
// depends on tgbc_pkg
module tgbc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_type,
   output logic                busy,
   output logic                rsp_valid,
   output tgbc_pkg::cmd_type    cmd,
   input  tgbc_pkg::status_type st
);
   import tgbc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_TEST  = 3'd3;
   localparam logic [2:0] S_ADDR  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] ph_ff, ph_in;
   logic       valid_ff, valid_in;
   logic       sweep;

   assign sweep     = (ph_ff == PH_LSPAN) || (ph_ff == PH_RSPAN);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      valid_in = 1'b0;
      cmd.op   = CMD_NONE;
      cmd.ph   = ph_ff;
      cmd.hit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_type == REQ_WRITE) begin
                  cmd.op = CMD_WRITE;
               end else begin
                  cmd.op   = CMD_CAPTURE;
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            cmd.op   = CMD_PREP;
            ph_in    = PH_LEFT;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.op   = CMD_SETUP;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (st.oor) begin
               cmd.op = CMD_RECORD;
            end else if (st.empty) begin
               if (sweep) cmd.op = CMD_OUTER;
               else cmd.op = CMD_RECORD;
            end else begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            cmd.op   = CMD_READ;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (st.hit) begin
               cmd.op  = CMD_RECORD;
               cmd.hit = 1'b1;
            end else if (st.last) begin
               if (sweep) begin
                  cmd.op   = CMD_OUTER;
                  state_in = S_TEST;
               end else begin
                  cmd.op = CMD_RECORD;
               end
            end else begin
               cmd.op   = CMD_INNER;
               state_in = S_ADDR;
            end
         end
         S_DONE: begin
            cmd.op   = CMD_EMIT;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a recorded phase moves on to the next one, and the last phase moves on to S_DONE
      if (cmd.op == CMD_RECORD) begin
         if (ph_ff == PH_RSPAN) begin
            state_in = S_DONE;
         end else begin
            ph_in    = ph_ff + 3'd1;
            state_in = S_SETUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= PH_LEFT;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- sv/tgbc_datapath.sv -----
// datapath: tile store, config registers, scan counters, lookup and result registers
// depends on tgbc_pkg
module tgbc_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tgbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tgbc_pkg::CODE_W-1:0]      csr_wdata,
   input  logic [tgbc_pkg::INDEX_W-1:0]     req_cell_index,
   input  logic [tgbc_pkg::CODE_W-1:0]      req_tile_code,
   input  logic signed [tgbc_pkg::IN_PIX_W-1:0] req_box_x,
   input  logic signed [tgbc_pkg::IN_PIX_W-1:0] req_box_y,
   input  logic [tgbc_pkg::SIZE_W-1:0]      req_box_width,
   input  logic [tgbc_pkg::SIZE_W-1:0]      req_box_height,
   input  logic signed [tgbc_pkg::IN_PIX_W-1:0] req_probe_y,
   input  tgbc_pkg::cmd_type                cmd,
   output tgbc_pkg::status_type             st,
   output logic                             rsp_wall_left,
   output logic                             rsp_wall_right,
   output logic                             rsp_on_ground,
   output logic signed [tgbc_pkg::IN_PIX_W-1:0] rsp_ground_y,
   output logic                             rsp_falling,
   output logic [tgbc_pkg::SWEEP_W-1:0]     rsp_sweep_x,
   output logic [tgbc_pkg::SWEEP_W-1:0]     rsp_sweep_width
);
   import tgbc_pkg::*;

   localparam logic signed [TILE_W-1:0] LEVEL_COL_S = TILE_W'(LEVEL_COLUMNS);
   localparam logic signed [TILE_W-1:0] ONE_T = TILE_W'(1);
   localparam logic signed [PIX_W:0]    GY_MIN = -(PIX_W + 1)'(1 << (IN_PIX_W - 1));
   localparam logic signed [PIX_W:0]    GY_MAX = (PIX_W + 1)'((1 << (IN_PIX_W - 1)) - 1);

   logic [CODE_W-1:0] mem [MAP_CELLS];

   logic [DIM_W-1:0]  map_width_ff, map_height_ff;
   logic [CODE_W-1:0] solid_first_ff, solid_last_ff;

   logic signed [PIX_W-1:0] bx_ff, by_ff, py_ff;
   logic [SIZE_W-1:0]       bw_ff, bh_ff;

   logic signed [TILE_W-1:0] col_l_ff, col_r_ff, r0_ff, r1_ff, rp_ff, rf_ff;
   logic signed [TILE_W-1:0] scol_ff, srow_ff, xl_ff, xr_ff;

   logic [CODE_W-1:0] rd_ff;
   logic              ok_ff;
   logic wall_l_ff, wall_r_ff, ground_ff, fall_ff;

   logic                     row_scan, col_empty, row_empty;
   logic signed [PIX_W-1:0]  right_pix, bottom_pix, below_pix;
   logic signed [PROD_W-1:0] prod;
   logic signed [IDX_W-1:0]  idx;
   logic [IDX_W-2:0]         idx_u;
   logic [CELLS_W-1:0]       cells;
   logic                     in_map;
   logic signed [PIX_W:0]    gsnap, gsat;
   logic signed [SPAN_W-1:0] left_pix, span_w;

   assign row_scan   = (cmd.ph == PH_GROUND) || (cmd.ph == PH_FALL);
   assign right_pix  = bx_ff + PIX_W'(bw_ff) - PIX_W'(1);
   assign bottom_pix = by_ff + PIX_W'(bh_ff) - PIX_W'(1);
   assign below_pix  = by_ff + PIX_W'(bh_ff);

   assign col_empty = r0_ff > r1_ff;
   assign row_empty = col_l_ff > col_r_ff;

   assign st.empty = row_scan ? row_empty : col_empty;
   assign st.oor   = ((cmd.ph == PH_LSPAN) && (scol_ff < 0)) ||
                     ((cmd.ph == PH_RSPAN) && (scol_ff >= LEVEL_COL_S));
   assign st.last  = row_scan ? (scol_ff == col_r_ff) : (srow_ff == r1_ff);
   assign st.hit   = ok_ff && (solid_first_ff <= rd_ff) && (rd_ff <= solid_last_ff);

   // linear index of the tile under the scan counters
   assign prod   = srow_ff * $signed({1'b0, map_width_ff});
   assign idx    = IDX_W'(scol_ff) + IDX_W'(prod);
   assign idx_u  = idx[IDX_W-2:0];
   assign cells  = map_width_ff * map_height_ff;
   assign in_map = !idx[IDX_W-1] && (idx_u < (IDX_W - 1)'(cells)) &&
                   (idx_u < (IDX_W - 1)'(MAP_CELLS));

   assign gsnap = ((PIX_W + 1)'(rp_ff) <<< TILE_SHIFT) - (PIX_W + 1)'(1);
   assign gsat  = (gsnap < GY_MIN) ? GY_MIN : ((gsnap > GY_MAX) ? GY_MAX : gsnap);

   assign left_pix = (SPAN_W'(xl_ff) + SPAN_W'(1)) <<< TILE_SHIFT;
   assign span_w   = (SPAN_W'(xr_ff) <<< TILE_SHIFT) - left_pix;

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_WRITE) begin
         if ({1'b0, req_cell_index} < (INDEX_W + 1)'(MAP_CELLS))
            mem[ADDR_W'(req_cell_index)] <= req_tile_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_READ) begin
         rd_ff <= mem[idx[ADDR_W-1:0]];
         ok_ff <= in_map;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= DIM_W'(32);
         map_height_ff  <= DIM_W'(32);
         solid_first_ff <= CODE_W'(1);
         solid_last_ff  <= CODE_W'(255);
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:   map_width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_MAP_HEIGHT:  map_height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_SOLID_FIRST: solid_first_ff <= csr_wdata;
            CSR_SOLID_LAST:  solid_last_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_CAPTURE: begin
            bx_ff <= PIX_W'(req_box_x);
            by_ff <= PIX_W'(req_box_y);
            py_ff <= PIX_W'(req_probe_y);
            bw_ff <= req_box_width;
            bh_ff <= req_box_height;
         end
         CMD_PREP: begin
            col_l_ff <= tile_of(bx_ff);
            col_r_ff <= tile_of(right_pix);
            r0_ff    <= tile_of(by_ff);
            r1_ff    <= tile_of(bottom_pix);
            rp_ff    <= tile_of(py_ff);
            rf_ff    <= tile_of(below_pix);
         end
         CMD_SETUP: begin
            case (cmd.ph)
               PH_LEFT:   begin scol_ff <= col_l_ff;         srow_ff <= r0_ff; end
               PH_RIGHT:  begin scol_ff <= col_r_ff;         srow_ff <= r0_ff; end
               PH_GROUND: begin scol_ff <= col_l_ff;         srow_ff <= rp_ff; end
               PH_FALL:   begin scol_ff <= col_l_ff;         srow_ff <= rf_ff; end
               PH_LSPAN:  begin scol_ff <= col_l_ff - ONE_T; srow_ff <= r0_ff; end
               default:   begin scol_ff <= col_l_ff + ONE_T; srow_ff <= r0_ff; end
            endcase
         end
         CMD_INNER: begin
            if (row_scan) scol_ff <= scol_ff + ONE_T;
            else srow_ff <= srow_ff + ONE_T;
         end
         CMD_OUTER: begin
            srow_ff <= r0_ff;
            if (cmd.ph == PH_LSPAN) scol_ff <= scol_ff - ONE_T;
            else scol_ff <= scol_ff + ONE_T;
         end
         CMD_RECORD: begin
            case (cmd.ph)
               PH_LEFT:   wall_l_ff <= cmd.hit;
               PH_RIGHT:  wall_r_ff <= cmd.hit;
               PH_GROUND: ground_ff <= cmd.hit;
               PH_FALL:   fall_ff   <= cmd.hit;
               PH_LSPAN:  xl_ff     <= scol_ff;
               default:   xr_ff     <= scol_ff;
            endcase
         end
         CMD_EMIT: begin
            rsp_wall_left   <= wall_l_ff;
            rsp_wall_right  <= wall_r_ff;
            rsp_on_ground   <= ground_ff;
            rsp_ground_y    <= ground_ff ? gsat[IN_PIX_W-1:0] : py_ff[IN_PIX_W-1:0];
            rsp_falling     <= !fall_ff;
            rsp_sweep_x     <= clamp_span(left_pix);
            rsp_sweep_width <= clamp_span(span_w);
         end
         default: ;
      endcase
   end

endmodule

// ----- sv/tgbc_checker.sv -----
// port level checks for the tile grid box collision block, bound to the top level
// depends on tile_grid_box_collision
module tgbc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_type,
   input logic rsp_valid
);

   // a query request always makes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type |=> busy)
      else $error("query request did not raise busy");

   // a cell write finishes in the cycle it is taken
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_type |=> !busy && !rsp_valid)
      else $error("cell write held the block or made a result");

   // a result only follows the end of a query
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe without a finished query");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

bind tile_grid_box_collision tgbc_checker u_tgbc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_type  (req_type),
   .rsp_valid (rsp_valid)
);
